>>> src/dual_crc32_stream_checker_defines.svh
// Assertion macros shared by the checker RTL.
// DCRC_ASSERT checks an expression at every clock edge out of reset.
// DCRC_ASSERT_NEXT checks that a condition implies another at the next clock edge.
`ifndef DUAL_CRC32_STREAM_CHECKER_DEFINES_SVH
`define DUAL_CRC32_STREAM_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define DCRC_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dcrc assertion failed");
`define DCRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcrc assertion failed");
`else
`define DCRC_ASSERT(label, expr)
`define DCRC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> src/dcrc_pkg.sv
package dcrc_pkg;

    localparam logic [31:0] CRC_ALL_ONES      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY_REFLECT  = 32'h82F6_3B78;
    localparam logic [31:0] CRC_POLY_NORMAL   = 32'h04C1_1DB7;

    // Mode codes
    localparam logic MODE_CRC32C_REFL = 1'b0;
    localparam logic MODE_CRC32_NORM  = 1'b1;

    // One input transfer held in the input register
    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic        last;
        logic [31:0] expected;
    } dcrc_item_t;

    // Reflected byte fold (LSB first), unrolls to an XOR tree
    function automatic logic [31:0] fold_reflected(input logic [31:0] acc_in,
                                                   input logic [7:0]  byte_in);
        logic [31:0] acc;
        acc = acc_in ^ {24'h0, byte_in};
        for (int k = 0; k < 8; k++)
        begin
            acc = (acc >> 1) ^ (acc[0] ? CRC_POLY_REFLECT : 32'h0);
        end
        return acc;
    endfunction

    // Non-reflected byte fold (MSB first)
    function automatic logic [31:0] fold_normal(input logic [31:0] acc_in,
                                                input logic [7:0]  byte_in);
        logic [31:0] acc;
        acc = acc_in ^ {byte_in, 24'h0};
        for (int k = 0; k < 8; k++)
        begin
            acc = (acc << 1) ^ (acc[31] ? CRC_POLY_NORMAL : 32'h0);
        end
        return acc;
    endfunction

endpackage

>>> src/dcrc_in_stage.sv
module dcrc_in_stage
    import dcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] expected_crc,
    input  logic        advance,
    output dcrc_item_t  item
);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  data_reg;
    logic        last_reg;
    logic [31:0] expected_reg;
    logic        load;

    // Hold off upstream only while the held item cannot move on
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg     <= data_byte;
            last_reg     <= last_byte;
            expected_reg <= expected_crc;
        end
    end

    assign item.valid    = valid_reg;
    assign item.data     = data_reg;
    assign item.last     = last_reg;
    assign item.expected = expected_reg;

endmodule

>>> src/dcrc_core.sv
module dcrc_core
    import dcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  dcrc_item_t  item,
    output logic        advance,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] crc_value,
    output logic        crc_match
);

    logic        mode_reg;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic        start_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] crc_value_reg;
    logic        crc_match_reg;
    logic [31:0] crc_base;
    logic [31:0] final_crc;
    logic        emit;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_CRC32C_REFL;
        else if (cfg_wr_en)
            mode_reg <= cfg_wr_data;
    end

    // Non-last bytes always move; a last byte needs a free result slot
    assign advance = item.valid && (!item.last || !out_valid_reg || !out_stall);
    assign emit    = advance && item.last;

    // Byte fold, seeded with the mode init on the first byte of a message
    always_comb
    begin
        if (start_reg)
            crc_base = (mode_reg == MODE_CRC32_NORM) ? 32'h0 : CRC_ALL_ONES;
        else
            crc_base = crc_reg;
        if (mode_reg == MODE_CRC32_NORM)
            crc_next = fold_normal(crc_base, item.data);
        else
            crc_next = fold_reflected(crc_base, item.data);
        final_crc = ~crc_next;
    end

    // Running CRC and message-start flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= 32'h0;
            start_reg <= 1'b1;
        end
        else if (advance)
        begin
            crc_reg   <= crc_next;
            start_reg <= item.last;
        end
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            crc_value_reg <= final_crc;
            crc_match_reg <= (final_crc == item.expected);
        end
    end

    assign out_valid = out_valid_reg;
    assign crc_value = crc_value_reg;
    assign crc_match = crc_match_reg;

endmodule

>>> src/dual_crc32_stream_checker.sv
// Streaming CRC-32 checker, one message byte per input transfer.
// Input channel: in_valid/in_stall with data_byte, last_byte, expected_crc
// (expected_crc is only looked at with the last byte of a message).
// Output channel: out_valid/out_stall with crc_value and crc_match, one
// transfer per message, produced by its last byte.
// Config: cfg_wr_en/cfg_wr_data write the mode bit (0 reflected CRC-32C with
// all-ones init, 1 non-reflected 0x04C11DB7 with zero init), while idle.
// Throughput: one byte per cycle while in_stall is low; the byte fold is a
// combinational XOR tree between the input register and the running CRC
// register. A last byte passes the input register, then the result register,
// before its result shows on the output.
// Reset clears the mode to CRC-32C, empties both registers and arms the
// start of a new message.
// When the receiver stalls, the result holds; further non-last bytes keep
// flowing, and in_stall rises only when a second last byte waits for the
// occupied result register.
module dual_crc32_stream_checker
    import dcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] expected_crc,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] crc_value,
    output logic        crc_match
);

`include "dual_crc32_stream_checker_defines.svh"

    dcrc_item_t item;
    logic       advance;

    dcrc_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .expected_crc (expected_crc),
        .advance      (advance),
        .item         (item)
    );

    dcrc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crc_value   (crc_value),
        .crc_match   (crc_match)
    );

    // Backpressure only comes from a held last byte behind a stalled result
    `DCRC_ASSERT(a_stall_cause, !in_stall || (item.valid && item.last && out_valid && out_stall))
    // A last byte that moves on always lands in the result register
    `DCRC_ASSERT_NEXT(a_last_emits, item.valid && item.last && advance, out_valid)
    // A result appears only from a moving last byte
    `DCRC_ASSERT_NEXT(a_no_spurious, !out_valid && !(item.valid && item.last), !out_valid)

endmodule
